@@ hw/rtl/dld_pkg.sv @@
// Shared types and constants of the digitizer link deframer.
package dld_pkg;

    // Result kinds, as seen on the result channel's tuser
    typedef enum logic [2:0] {
        KIND_START    = 3'd0,
        KIND_STOP     = 3'd1,
        KIND_OTHER    = 3'd2,
        KIND_HEADER   = 3'd3,
        KIND_SAMPLES  = 3'd4,
        KIND_TRAILER  = 3'd5,
        KIND_OVERFLOW = 3'd6
    } kind_t;

    // Word classes decided by the front end
    typedef enum logic [1:0] {
        CLS_START = 2'd0,
        CLS_STOP  = 2'd1,
        CLS_OTHER = 2'd2,
        CLS_DATA  = 2'd3
    } cls_t;

    // One classified word as held in the queue
    typedef struct packed {
        cls_t        cls;
        logic [31:0] word;
    } q_item_t;

    // One result item
    typedef struct packed {
        kind_t       kind;
        logic [3:0]  sample_index;
        logic [5:0]  first_channel;
        logic [9:0]  value_a;
        logic [9:0]  value_b;
        logic [9:0]  value_c;
        logic [11:0] bunch_number;
        logic [1:0]  run_mode;
        logic [2:0]  gain_bits;
        logic [3:0]  header_length;
        logic [4:0]  error_flags;
        logic [3:0]  variable_parity;
    } result_t;

    // Configuration register indexes
    localparam logic [1:0] REG_SAMPLES = 2'd0;
    localparam logic [1:0] REG_START   = 2'd1;
    localparam logic [1:0] REG_STOP    = 2'd2;

    // Configuration reset values
    localparam logic [3:0]  SAMPLES_RESET = 4'd13;
    localparam logic [31:0] START_RESET   = 32'h1111_1110;
    localparam logic [31:0] STOP_RESET    = 32'hffff_fff0;

endpackage

@@ hw/rtl/dld_front.sv @@
// Front end: classifies each accepted link word against the control values.
module dld_front (
    input  logic             is_control,
    input  logic [31:0]      link_word,
    input  logic [31:0]      start_value,
    input  logic [31:0]      stop_value,
    output dld_pkg::q_item_t item
);
    import dld_pkg::*;

    // Control words are compared with the configured start and stop values
    always_comb begin
        item.word = link_word;
        priority if (!is_control) begin
            item.cls = CLS_DATA;
        end else if (link_word == start_value) begin
            item.cls = CLS_START;
        end else if (link_word == stop_value) begin
            item.cls = CLS_STOP;
        end else begin
            item.cls = CLS_OTHER;
        end
    end

endmodule

@@ hw/rtl/dld_queue.sv @@
// Two-entry queue between the front end and the back end.
module dld_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  dld_pkg::q_item_t push_item,
    output logic             not_full,
    input  logic             pop,
    output logic             not_empty,
    output dld_pkg::q_item_t pop_item
);
    import dld_pkg::*;

    q_item_t    mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign not_full  = (count_reg != 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_item  = mem_reg[rd_ptr_reg];

    // Pointer and fill count update; a push and a pop may share a cycle
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ hw/rtl/dld_back.sv @@
// Back end: framing state, sample decode and the output register.
module dld_back #(
    parameter int NUM_CHANNELS = 48,
    parameter int SWAP_CHANNEL = 24
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [3:0]       samples_per_channel,
    input  logic             q_valid,
    input  dld_pkg::q_item_t q_item,
    output logic             q_pop,
    output logic             out_valid,
    input  logic             out_ready,
    output dld_pkg::result_t out_result
);
    import dld_pkg::*;

    localparam logic [8:0] NUM_CH = 9'(NUM_CHANNELS);
    localparam logic [8:0] SWAP_CH = 9'(SWAP_CHANNEL);

    logic       expect_header_reg, expect_header_next;
    logic [4:0] sample_count_reg, sample_count_next;
    logic [4:0] channel_group_reg, channel_group_next;
    logic       group_started_reg, group_started_next;
    logic       out_valid_reg, out_valid_next;
    result_t    out_reg, out_next;

    logic [5:0] grp;
    logic [8:0] base;
    logic [4:0] sample_limit;
    logic [31:0] w;
    logic [8:0] cur_top;

    assign q_pop      = q_valid && (!out_valid_reg || out_ready);
    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;
    assign w          = q_item.word;

    // Group that a data word would land in, and its first channel less one
    always_comb begin
        if (sample_count_reg == 5'd0) begin
            grp = group_started_reg ? ({1'b0, channel_group_reg} + 6'd1) : 6'd0;
        end else begin
            grp = {1'b0, channel_group_reg};
        end
        base         = {2'b00, grp, 1'b0} + {3'b000, grp};
        sample_limit = {1'b0, samples_per_channel} + 5'd1;
    end

    // Result decode and next state
    always_comb begin
        expect_header_next = expect_header_reg;
        sample_count_next  = sample_count_reg;
        channel_group_next = channel_group_reg;
        group_started_next = group_started_reg;
        out_next           = out_reg;
        out_valid_next     = out_valid_reg && !out_ready;
        if (q_pop) begin
            out_valid_next = 1'b1;
            out_next       = '0;
            unique case (q_item.cls)
                CLS_START: begin
                    out_next.kind      = KIND_START;
                    channel_group_next = 5'd0;
                    group_started_next = 1'b0;
                end
                CLS_STOP: begin
                    out_next.kind = KIND_STOP;
                end
                CLS_OTHER: begin
                    out_next.kind = KIND_OTHER;
                end
                default: begin
                    priority if (expect_header_reg && w[31]) begin
                        out_next.kind            = KIND_HEADER;
                        out_next.bunch_number    = w[11:0];
                        out_next.run_mode        = w[16:15];
                        out_next.gain_bits       = w[14:12];
                        out_next.header_length   = w[29:26];
                        out_next.error_flags     = {w[22], w[23], w[24], w[25], w[30]};
                        out_next.variable_parity = w[21:18];
                        expect_header_next       = 1'b0;
                        sample_count_next        = 5'd0;
                    end else if (sample_count_reg < sample_limit) begin
                        if (((base + 9'd3) > NUM_CH) || grp[5]) begin
                            // Group overrun: the samples are dropped for an overflow result, no state moves
                            out_next.kind = KIND_OVERFLOW;
                        end else begin
                            out_next.kind          = KIND_SAMPLES;
                            out_next.sample_index  = sample_count_reg[3:0];
                            out_next.first_channel = 6'(base + 9'd1);
                            if (base < SWAP_CH) begin
                                out_next.value_a = w[9:0];
                                out_next.value_c = w[29:20];
                            end else begin
                                out_next.value_a = w[29:20];
                                out_next.value_c = w[9:0];
                            end
                            out_next.value_b   = w[19:10];
                            channel_group_next = grp[4:0];
                            group_started_next = 1'b1;
                            sample_count_next  = sample_count_reg + 5'd1;
                        end
                    end else begin
                        out_next.kind      = KIND_TRAILER;
                        expect_header_next = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expect_header_reg <= 1'b1;
            sample_count_reg  <= 5'd0;
            channel_group_reg <= 5'd0;
            group_started_reg <= 1'b0;
            out_valid_reg     <= 1'b0;
        end else begin
            expect_header_reg <= expect_header_next;
            sample_count_reg  <= sample_count_next;
            channel_group_reg <= channel_group_next;
            group_started_reg <= group_started_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // Output payload register
    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    // Top channel of the current group, for the checks below
    assign cur_top = {3'b000, channel_group_reg, 1'b0} + {4'b0000, channel_group_reg} + 9'd3;

    // The sample count never runs past one more than the largest setting
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        sample_count_reg <= 5'd16)
        else $error("sample count out of range");

    // A started group always lies wholly inside the channel range
    a_group_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        group_started_reg |-> (cur_top <= NUM_CH))
        else $error("channel group past last channel");

    // A header result leaves the block no longer expecting a header
    a_header_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && out_next.kind == KIND_HEADER) |=> !expect_header_reg)
        else $error("header expectation not cleared");

endmodule

@@ hw/rtl/digitizer_link_deframer.sv @@
// Top level of the digitizer link deframer: ports, configuration registers, wiring.
//
//  Channel   Direction  Payload
//  s_axis    in         tdata: link_word; tuser: is_control
//  m_axis    out        tdata: deframed fields; tuser: kind
//  apb       in/out     samples_per_channel @0, start value @4, stop value @8
//
//  One link word is taken every cycle while the queue has room (s_tready high); its result
//  is held in the queue and then in the output register before it is offered on m_axis.
//  Throughput is set by the two-entry queue and the single output register.
//  Reset (aresetn low at a clock edge) empties the queue and output and restores state.
//  A stalled result channel fills the output register, then the queue, then drops s_tready.
module digitizer_link_deframer #(
    parameter int NUM_CHANNELS = 48,
    parameter int SWAP_CHANNEL = 24
) (
    input  logic        aclk,
    input  logic        aresetn,
    // link_word [31:0]
    input  logic [31:0] s_tdata,
    // is_control [0]
    input  logic [0:0]  s_tuser,
    input  logic        s_tvalid,
    output logic        s_tready,
    // sample_index [3:0], first_channel [9:4], value_a [19:10], value_b [29:20],
    // value_c [39:30], bunch_number [51:40], run_mode [53:52], gain_bits [56:54],
    // header_length [60:57], error_flags [65:61], variable_parity [69:66], zero [71:70]
    output logic [71:0] m_tdata,
    // kind [2:0]
    output logic [2:0]  m_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import dld_pkg::*;

    logic [3:0]  samples_reg;
    logic [31:0] start_reg;
    logic [31:0] stop_reg;
    logic        cfg_write;
    q_item_t     front_item;
    q_item_t     q_item;
    logic        q_not_full;
    logic        q_not_empty;
    logic        q_pop;
    logic        s_push;
    result_t     res;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            samples_reg <= SAMPLES_RESET;
            start_reg   <= START_RESET;
            stop_reg    <= STOP_RESET;
        end else if (cfg_write) begin
            unique case (paddr[3:2])
                REG_SAMPLES: samples_reg <= pwdata[3:0];
                REG_START:   start_reg   <= pwdata;
                REG_STOP:    stop_reg    <= pwdata;
                default:     ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_SAMPLES: prdata = {28'd0, samples_reg};
            REG_START:   prdata = start_reg;
            REG_STOP:    prdata = stop_reg;
            default:     prdata = 32'd0;
        endcase
    end

    // Front end and queue
    assign s_tready = q_not_full;
    assign s_push   = s_tvalid && q_not_full;

    dld_front u_front (
        .is_control  (s_tuser[0]),
        .link_word   (s_tdata),
        .start_value (start_reg),
        .stop_value  (stop_reg),
        .item        (front_item)
    );

    dld_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_push),
        .push_item (front_item),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_item  (q_item)
    );

    // Back end
    dld_back #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .SWAP_CHANNEL (SWAP_CHANNEL)
    ) u_back (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .samples_per_channel (samples_reg),
        .q_valid             (q_not_empty),
        .q_item              (q_item),
        .q_pop               (q_pop),
        .out_valid           (m_tvalid),
        .out_ready           (m_tready),
        .out_result          (res)
    );

    // Result packing
    assign m_tuser = res.kind;
    assign m_tdata = {2'b00, res.variable_parity, res.error_flags, res.header_length,
                      res.gain_bits, res.run_mode, res.bunch_number, res.value_c,
                      res.value_b, res.value_a, res.first_channel, res.sample_index};

endmodule
